### hw/rtl/lrs_pkg.sv
// Shared types and constants for the line rasterizer with stroke.
// Used by every module of the block but the queue; depends on nothing else.
`default_nettype none

package lrs_pkg;

    // Field widths fixed by the stream formats, and the queue depth.
    localparam int IN_COORD_W  = 12;
    localparam int STROKE_W    = 5;
    localparam int PIX_W       = 14;
    localparam int ADDR_W      = 27;
    localparam int COLOR_W     = 24;
    localparam int PITCH_W     = 14;
    localparam int CFG_ADDR_W  = 1;
    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 80;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [PITCH_W-1:0] PITCH_RESET = '0;
    localparam logic [COLOR_W-1:0] COLOR_RESET = 24'hFFFFFF;

    typedef enum logic [0:0] {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } opcode_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ROW_PITCH  = 1'b0,
        CFG_DRAW_COLOR = 1'b1
    } cfg_index_t;

endpackage

`default_nettype wire

### hw/rtl/line_rasterizer_with_stroke_top.sv
// Top level of the line rasterizer with stroke: configuration registers,
// line walker, decoupling queue and address pipeline. Uses lrs_pkg.
//
//   Channel   Direction  Handshake           Contents
//   s_*       in         s_tvalid/s_tready   start or tick item
//   m_*       out        m_tvalid/m_tready   one pixel write
//   cfg_*     in         cfg_we              row pitch or draw color
//
// One tick is taken per cycle unless the queue is full and yields one pixel while
// a line is active; the walker does one stroke offset per tick and one Bresenham
// step per stroke. Pixels are registered in the queue, the multiply stage and the
// output stage. The four-entry queue absorbs output stalls; s_tready falls only
// when it is full. Reset clears the walker, the queue and the output valid at once.
`default_nettype none

module line_rasterizer_with_stroke_top #(
    parameter int COORD_BITS = 12,
    parameter int MAX_STROKE = 31
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // s_tdata from bit 0: x_start, y_start, x_end, y_end, stroke_width, zero fill
    input  wire logic [lrs_pkg::IN_DATA_W-1:0]       s_tdata,
    // s_tuser: opcode
    input  wire logic                                s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // m_tdata from bit 0: pixel_x, pixel_y, pixel_address, pixel_bytes, zero fill
    output logic [lrs_pkg::OUT_DATA_W-1:0]           m_tdata,
    // m_tuser: off_screen
    output logic                                     m_tuser,
    output logic                                     m_tlast,
    input  wire logic                                cfg_we,
    input  wire logic [lrs_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [lrs_pkg::COLOR_W-1:0]         cfg_wdata
);

    localparam int CW = COORD_BITS + 2;
    localparam int QW = 2 * CW + 1;

    logic [lrs_pkg::PITCH_W-1:0] row_pitch_reg;
    logic [lrs_pkg::COLOR_W-1:0] draw_color_reg;

    logic          push;
    logic [QW-1:0] push_data;
    logic          q_full;
    logic          pop;
    logic          q_not_empty;
    logic [QW-1:0] q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pitch_reg  <= lrs_pkg::PITCH_RESET;
            draw_color_reg <= lrs_pkg::COLOR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                lrs_pkg::CFG_ROW_PITCH:  row_pitch_reg  <= cfg_wdata[lrs_pkg::PITCH_W-1:0];
                lrs_pkg::CFG_DRAW_COLOR: draw_color_reg <= cfg_wdata;
                default:                 row_pitch_reg  <= row_pitch_reg;
            endcase
        end
    end

    lrs_front #(
        .COORD_BITS (COORD_BITS),
        .MAX_STROKE (MAX_STROKE),
        .CW         (CW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    lrs_queue #(
        .WIDTH (QW),
        .DEPTH (lrs_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    lrs_back #(
        .CW (CW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_data),
        .pop         (pop),
        .row_pitch   (row_pitch_reg),
        .draw_color  (draw_color_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire

### hw/rtl/lrs_queue.sv
// Short first-in first-out queue that decouples the line walker from the
// address pipeline. Uses lrs_pkg only through its instantiating modules.
`default_nettype none

module lrs_queue #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds its depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

### hw/rtl/lrs_front.sv
// Input side: takes start and tick transfers and walks the line with Bresenham
// steps and stroke offsets, pushing one pixel per tick while active. Uses lrs_pkg.
`default_nettype none

module lrs_front #(
    parameter int COORD_BITS = 12,
    parameter int MAX_STROKE = 31,
    parameter int CW         = COORD_BITS + 2
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [lrs_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire logic                           s_tuser,
    input  wire logic                           q_full,
    output logic                                push,
    output logic [2*CW:0]                       push_data
);

    localparam int CB   = COORD_BITS;
    localparam int ICW  = lrs_pkg::IN_COORD_W;
    localparam int SW   = lrs_pkg::STROKE_W;

    logic          accept;
    logic          is_start;
    logic [CB-1:0] x1;
    logic [CB-1:0] y1;
    logic [CB-1:0] x2;
    logic [CB-1:0] y2;
    logic [SW-1:0] stroke_in;
    logic [SW-1:0] stroke_sat;
    logic [CB-1:0] adx;
    logic [CB-1:0] ady;
    logic          start_x_major;
    logic [CB-1:0] start_major;

    logic          active_reg,      active_next;
    logic [CB-1:0] cur_x_reg,       cur_x_next;
    logic [CB-1:0] cur_y_reg,       cur_y_next;
    logic [CB:0]   error_acc_reg,   error_acc_next;
    logic [CB-1:0] abs_dx_reg,      abs_dx_next;
    logic [CB-1:0] abs_dy_reg,      abs_dy_next;
    logic          neg_x_reg,       neg_x_next;
    logic          neg_y_reg,       neg_y_next;
    logic          x_major_reg,     x_major_next;
    logic [CB-1:0] steps_left_reg,  steps_left_next;
    logic [SW-1:0] stroke_left_reg, stroke_left_next;
    logic [SW-1:0] stroke_set_reg,  stroke_set_next;

    logic [CB-1:0] major;
    logic [CB-1:0] minor;
    logic [CB:0]   err_sum;
    logic          minor_step;
    logic [SW-1:0] sl;
    logic [CW-1:0] off_mag;
    logic [CW-1:0] off_val;
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic          fin;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign is_start = (s_tuser == lrs_pkg::OP_START);

    assign x1        = CB'(s_tdata[ICW-1:0]);
    assign y1        = CB'(s_tdata[2*ICW-1:ICW]);
    assign x2        = CB'(s_tdata[3*ICW-1:2*ICW]);
    assign y2        = CB'(s_tdata[4*ICW-1:3*ICW]);
    assign stroke_in = s_tdata[4*ICW+SW-1:4*ICW];
    assign stroke_sat = (int'(stroke_in) > MAX_STROKE) ? SW'(MAX_STROKE) : stroke_in;

    assign adx           = (x2 < x1) ? (x1 - x2) : (x2 - x1);
    assign ady           = (y2 < y1) ? (y1 - y2) : (y2 - y1);
    assign start_x_major = (adx >= ady);
    assign start_major   = start_x_major ? adx : ady;

    assign major      = x_major_reg ? abs_dx_reg : abs_dy_reg;
    assign minor      = x_major_reg ? abs_dy_reg : abs_dx_reg;
    assign err_sum    = error_acc_reg + (CB + 1)'(minor);
    assign minor_step = (err_sum >= (CB + 1)'(major));

    always_comb
    begin
        active_next      = active_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        error_acc_next   = error_acc_reg;
        abs_dx_next      = abs_dx_reg;
        abs_dy_next      = abs_dy_reg;
        neg_x_next       = neg_x_reg;
        neg_y_next       = neg_y_reg;
        x_major_next     = x_major_reg;
        steps_left_next  = steps_left_reg;
        stroke_left_next = stroke_left_reg;
        stroke_set_next  = stroke_set_reg;
        push             = 1'b0;
        sl               = stroke_left_reg;

        if (stroke_left_reg == '0)
        begin
            sl = stroke_set_reg;
            if (x_major_reg)
            begin
                cur_x_next = neg_x_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
                if (minor_step)
                begin
                    cur_y_next = neg_y_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
                end
            end
            else
            begin
                cur_y_next = neg_y_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
                if (minor_step)
                begin
                    cur_x_next = neg_x_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
                end
            end
            error_acc_next  = minor_step ? err_sum - (CB + 1)'(major) : err_sum;
            steps_left_next = steps_left_reg - 1'b1;
        end

        off_mag = CW'(sl[SW-1:1]);
        off_val = sl[0] ? (CW'(0) - off_mag) : off_mag;
        cx      = CW'(cur_x_next);
        cy      = CW'(cur_y_next);
        px      = x_major_reg ? cx : cx + off_val;
        py      = x_major_reg ? cy + off_val : cy;
        fin     = (sl == SW'(1)) && (steps_left_next == '0);
        stroke_left_next = sl - 1'b1;
        if (fin)
        begin
            active_next = 1'b0;
        end

        if (!(accept && !is_start && active_reg))
        begin
            active_next      = active_reg;
            cur_x_next       = cur_x_reg;
            cur_y_next       = cur_y_reg;
            error_acc_next   = error_acc_reg;
            steps_left_next  = steps_left_reg;
            stroke_left_next = stroke_left_reg;
        end
        else
        begin
            push = 1'b1;
        end

        if (accept && is_start)
        begin
            abs_dx_next      = adx;
            abs_dy_next      = ady;
            neg_x_next       = (x2 < x1);
            neg_y_next       = (y2 < y1);
            x_major_next     = start_x_major;
            cur_x_next       = x1;
            cur_y_next       = y1;
            error_acc_next   = (CB + 1)'(start_major >> 1);
            steps_left_next  = start_major;
            stroke_set_next  = stroke_sat;
            stroke_left_next = '0;
            active_next      = (start_major != '0) && (stroke_sat != '0);
        end
    end

    assign push_data = {fin, py, px};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            error_acc_reg   <= '0;
            abs_dx_reg      <= '0;
            abs_dy_reg      <= '0;
            neg_x_reg       <= 1'b0;
            neg_y_reg       <= 1'b0;
            x_major_reg     <= 1'b0;
            steps_left_reg  <= '0;
            stroke_left_reg <= '0;
            stroke_set_reg  <= '0;
        end
        else
        begin
            active_reg      <= active_next;
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            error_acc_reg   <= error_acc_next;
            abs_dx_reg      <= abs_dx_next;
            abs_dy_reg      <= abs_dy_next;
            neg_x_reg       <= neg_x_next;
            neg_y_reg       <= neg_y_next;
            x_major_reg     <= x_major_next;
            steps_left_reg  <= steps_left_next;
            stroke_left_reg <= stroke_left_next;
            stroke_set_reg  <= stroke_set_next;
        end
    end

    a_idle_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> !push)
        else $error("pixel pushed while no line is active");

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_data[2*CW]) |=> !active_reg)
        else $error("line still active after its last pixel");

    a_steps_remain: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && stroke_left_reg == '0) |-> (steps_left_reg != '0))
        else $error("active line has no major step left");

endmodule

`default_nettype wire

### hw/rtl/lrs_back.sv
// Output side: turns queued pixels into frame buffer writes with a
// registered multiply stage and an output register. Uses lrs_pkg.
`default_nettype none

module lrs_back #(
    parameter int CW = 14
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             q_not_empty,
    input  wire logic [2*CW:0]                    q_data,
    output logic                                  pop,
    input  wire logic [lrs_pkg::PITCH_W-1:0]      row_pitch,
    input  wire logic [lrs_pkg::COLOR_W-1:0]      draw_color,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [lrs_pkg::OUT_DATA_W-1:0]        m_tdata,
    output logic                                  m_tuser,
    output logic                                  m_tlast
);

    localparam int AW = lrs_pkg::ADDR_W;
    localparam int PW = lrs_pkg::PIX_W;
    localparam int UW = CW - 1;

    logic [CW-1:0] q_px;
    logic [CW-1:0] q_py;
    logic          q_fin;
    logic          out_adv;
    logic          s1_load;

    logic          s1_valid_reg;
    logic [AW-1:0] s1_prod_reg;
    logic [AW-1:0] s1_px3_reg;
    logic [CW-1:0] s1_px_reg;
    logic [CW-1:0] s1_py_reg;
    logic          s1_neg_reg;
    logic          s1_fin_reg;

    logic          out_valid_reg;
    logic [PW-1:0] out_x_reg;
    logic [PW-1:0] out_y_reg;
    logic [AW-1:0] out_addr_reg;
    logic          out_neg_reg;
    logic          out_fin_reg;

    assign q_px  = q_data[CW-1:0];
    assign q_py  = q_data[2*CW-1:CW];
    assign q_fin = q_data[2*CW];

    assign out_adv = !out_valid_reg || m_tready;
    assign s1_load = !s1_valid_reg || out_adv;
    assign pop     = q_not_empty && s1_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= q_not_empty;
            end
            if (out_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_prod_reg <= AW'(row_pitch) * AW'(q_py[UW-1:0]);
            s1_px3_reg  <= AW'({q_px[UW-1:0], 1'b0}) + AW'(q_px[UW-1:0]);
            s1_px_reg   <= q_px;
            s1_py_reg   <= q_py;
            s1_neg_reg  <= q_px[CW-1] || q_py[CW-1];
            s1_fin_reg  <= q_fin;
        end
        if (out_adv && s1_valid_reg)
        begin
            out_x_reg    <= PW'($signed(s1_px_reg));
            out_y_reg    <= PW'($signed(s1_py_reg));
            out_addr_reg <= s1_neg_reg ? '0 : s1_prod_reg + s1_px3_reg;
            out_neg_reg  <= s1_neg_reg;
            out_fin_reg  <= s1_fin_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, draw_color, out_addr_reg, out_y_reg, out_x_reg};
    assign m_tuser  = out_neg_reg;
    assign m_tlast  = out_fin_reg;

    a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_not_empty)
        else $error("pop without queued pixel");

    a_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_adv) |=> s1_valid_reg)
        else $error("multiply stage dropped a pixel under stall");

    a_offscreen_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_neg_reg) |-> (out_addr_reg == '0))
        else $error("off-screen pixel carries an address");

endmodule

`default_nettype wire

### tb/tb_line_rasterizer_with_stroke_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for line_rasterizer_with_stroke_top: drives configuration
// writes and start and tick transfers, predicts each pixel write in a scoreboard and
// compares it field by field. Depends on lrs_pkg and the top level only.

module tb_line_rasterizer_with_stroke_top;

    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 155;
    localparam int PY_LO         = lrs_pkg::PIX_W;
    localparam int ADDR_LO       = 2 * lrs_pkg::PIX_W;
    localparam int COLOR_LO      = 2 * lrs_pkg::PIX_W + lrs_pkg::ADDR_W;
    localparam int COORD_MAX     = (1 << lrs_pkg::IN_COORD_W) - 1;

    typedef struct {
        logic [lrs_pkg::PIX_W-1:0]   px;
        logic [lrs_pkg::PIX_W-1:0]   py;
        logic [lrs_pkg::ADDR_W-1:0]  addr;
        logic [lrs_pkg::COLOR_W-1:0] color;
        logic                        off_screen;
        logic                        last_pixel;
    } pixel_write_t;

    class stroke_line_tracker;
        int unsigned    row_pitch;
        int unsigned    draw_color;
        bit             active;
        bit             x_major;
        int             cur_x;
        int             cur_y;
        int             err_acc;
        int             abs_dx;
        int             abs_dy;
        int             step_x;
        int             step_y;
        int             steps_left;
        int             stroke_left;
        int             stroke_set;
        int             errors;
        int             items_taken;
        pixel_write_t   pending_pixels[$];

        function new();
            row_pitch   = 32'(lrs_pkg::PITCH_RESET);
            draw_color  = 32'(lrs_pkg::COLOR_RESET);
            active      = 1'b0;
            x_major     = 1'b0;
            cur_x       = 0;
            cur_y       = 0;
            err_acc     = 0;
            abs_dx      = 0;
            abs_dy      = 0;
            step_x      = 0;
            step_y      = 0;
            steps_left  = 0;
            stroke_left = 0;
            stroke_set  = 0;
            errors      = 0;
            items_taken = 0;
        endfunction

        function void set_register(lrs_pkg::cfg_index_t idx,
                                   logic [lrs_pkg::COLOR_W-1:0] value);
            if (idx == lrs_pkg::CFG_ROW_PITCH)
                row_pitch = 32'(value[lrs_pkg::PITCH_W-1:0]);
            else
                draw_color = 32'(value);
        endfunction

        function void take_item(lrs_pkg::opcode_t op, logic [lrs_pkg::IN_DATA_W-1:0] data);
            int           x1;
            int           y1;
            int           x2;
            int           y2;
            int           dx;
            int           dy;
            int           off;
            int           px;
            int           py;
            logic [31:0]  sum;
            pixel_write_t pix;
            items_taken++;
            if (op == lrs_pkg::OP_START)
            begin
                x1 = int'(data[11:0]);
                y1 = int'(data[23:12]);
                x2 = int'(data[35:24]);
                y2 = int'(data[47:36]);
                stroke_set = int'(data[52:48]);
                dx = x2 - x1;
                dy = y2 - y1;
                abs_dx = dx < 0 ? -dx : dx;
                abs_dy = dy < 0 ? -dy : dy;
                step_x = dx > 0 ? 1 : (dx < 0 ? -1 : 0);
                step_y = dy > 0 ? 1 : (dy < 0 ? -1 : 0);
                x_major = abs_dx >= abs_dy;
                cur_x = x1;
                cur_y = y1;
                err_acc = x_major ? abs_dx / 2 : abs_dy / 2;
                steps_left = x_major ? abs_dx : abs_dy;
                stroke_left = 0;
                active = steps_left > 0 && stroke_set > 0;
                return;
            end
            if (!active)
                return;
            if (stroke_left == 0)
            begin
                if (x_major)
                begin
                    err_acc += abs_dy;
                    if (err_acc >= abs_dx)
                    begin
                        err_acc -= abs_dx;
                        cur_y += step_y;
                    end
                    cur_x += step_x;
                end
                else
                begin
                    err_acc += abs_dx;
                    if (err_acc >= abs_dy)
                    begin
                        err_acc -= abs_dy;
                        cur_x += step_x;
                    end
                    cur_y += step_y;
                end
                steps_left--;
                stroke_left = stroke_set;
            end
            off = stroke_left / 2;
            if (stroke_left % 2 == 1)
                off = -off;
            px = cur_x;
            py = cur_y;
            if (x_major)
                py += off;
            else
                px += off;
            stroke_left--;
            pix.last_pixel = stroke_left == 0 && steps_left == 0;
            if (pix.last_pixel)
                active = 1'b0;
            pix.off_screen = px < 0 || py < 0;
            sum = pix.off_screen ? 32'd0 : row_pitch * py + 3 * px;
            pix.addr  = sum[lrs_pkg::ADDR_W-1:0];
            pix.px    = px[lrs_pkg::PIX_W-1:0];
            pix.py    = py[lrs_pkg::PIX_W-1:0];
            pix.color = draw_color[lrs_pkg::COLOR_W-1:0];
            pending_pixels.push_back(pix);
        endfunction

        function void compare_field(string label, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                         $time, label, want, got);
            end
        endfunction

        function void check_pixel(logic [lrs_pkg::OUT_DATA_W-1:0] data, logic off_screen,
                                  logic last_pixel);
            pixel_write_t want;
            if (pending_pixels.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected pixel transfer: expected none, actual 0x%0h",
                         $time, data);
                return;
            end
            want = pending_pixels.pop_front();
            compare_field("pixel_x", want.px, data[PY_LO-1:0]);
            compare_field("pixel_y", want.py, data[ADDR_LO-1:PY_LO]);
            compare_field("pixel_address", want.addr, data[COLOR_LO-1:ADDR_LO]);
            compare_field("pixel_bytes", want.color,
                          data[COLOR_LO+lrs_pkg::COLOR_W-1:COLOR_LO]);
            compare_field("off_screen", want.off_screen, off_screen);
            compare_field("last", want.last_pixel, last_pixel);
        endfunction
    endclass

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [lrs_pkg::IN_DATA_W-1:0]   s_tdata   = '0;
    logic                            s_tuser   = lrs_pkg::OP_START;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [lrs_pkg::OUT_DATA_W-1:0]  m_tdata;
    logic                            m_tuser;
    logic                            m_tlast;
    logic                            cfg_we    = 1'b0;
    logic [lrs_pkg::CFG_ADDR_W-1:0]  cfg_addr  = lrs_pkg::CFG_ROW_PITCH;
    logic [lrs_pkg::COLOR_W-1:0]     cfg_wdata = '0;

    int                     send_idle_pct = 0;
    int                     recv_stall_pct = 0;
    int                     quiet_cycles = 0;
    stroke_line_tracker     tracker = new();

    line_rasterizer_with_stroke_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= $urandom_range(99) >= recv_stall_pct;
    end

    // Handshakes are sampled mid-cycle; every input only changes at the rising edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                tracker.check_pixel(m_tdata, m_tuser, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_line_rasterizer_with_stroke_top NOT OK");
            $finish;
        end
    end

    task automatic push_item(input lrs_pkg::opcode_t op,
                             input logic [lrs_pkg::IN_DATA_W-1:0] data);
        bit granted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        granted = 1'b0;
        while (!granted)
        begin
            @(negedge clk);
            granted = s_tready;
            @(posedge clk);
        end
        tracker.take_item(op, data);
    endtask

    task automatic send_start(input int x1, input int y1, input int x2, input int y2,
                              input int stroke);
        logic [lrs_pkg::IN_DATA_W-1:0] data;
        data = '0;
        data[11:0]  = x1[lrs_pkg::IN_COORD_W-1:0];
        data[23:12] = y1[lrs_pkg::IN_COORD_W-1:0];
        data[35:24] = x2[lrs_pkg::IN_COORD_W-1:0];
        data[47:36] = y2[lrs_pkg::IN_COORD_W-1:0];
        data[52:48] = stroke[lrs_pkg::STROKE_W-1:0];
        push_item(lrs_pkg::OP_START, data);
    endtask

    task automatic send_ticks(input int count);
        logic [lrs_pkg::IN_DATA_W-1:0] noise;
        repeat (count)
        begin
            noise = lrs_pkg::IN_DATA_W'({$urandom, $urandom});
            noise[lrs_pkg::IN_DATA_W-1:53] = '0;
            push_item(lrs_pkg::OP_TICK, noise);
        end
    endtask

    task automatic write_config(input int unsigned pitch, input int unsigned color);
        cfg_we    <= 1'b1;
        cfg_addr  <= lrs_pkg::CFG_ROW_PITCH;
        cfg_wdata <= lrs_pkg::COLOR_W'(pitch);
        @(posedge clk);
        cfg_addr  <= lrs_pkg::CFG_DRAW_COLOR;
        cfg_wdata <= lrs_pkg::COLOR_W'(color);
        @(posedge clk);
        cfg_we    <= 1'b0;
        tracker.set_register(lrs_pkg::CFG_ROW_PITCH, lrs_pkg::COLOR_W'(pitch));
        tracker.set_register(lrs_pkg::CFG_DRAW_COLOR, lrs_pkg::COLOR_W'(color));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (tracker.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic int pick_coord();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return $urandom_range(3);
        if (r < 50)
            return COORD_MAX - 3 + $urandom_range(3);
        return $urandom_range(COORD_MAX);
    endfunction

    function automatic int clamp_coord(input int v);
        return v < 0 ? 0 : (v > COORD_MAX ? COORD_MAX : v);
    endfunction

    task automatic random_line(input bit cut_short);
        int r;
        int stroke;
        int span;
        int x1;
        int y1;
        int x2;
        int y2;
        int ax;
        int ay;
        int ticks;
        r = $urandom_range(99);
        stroke = r < 70 ? $urandom_range(4, 1) :
                 (r < 90 ? $urandom_range(12, 5) : $urandom_range(31, 13));
        span = (stroke <= 2 && $urandom_range(3) == 0) ? 40 : (stroke > 12 ? 3 : 6);
        x1 = pick_coord();
        y1 = pick_coord();
        x2 = clamp_coord(x1 + int'($urandom_range(2 * span)) - span);
        y2 = clamp_coord(y1 + int'($urandom_range(2 * span)) - span);
        ax = x2 > x1 ? x2 - x1 : x1 - x2;
        ay = y2 > y1 ? y2 - y1 : y1 - y2;
        ticks = (ax > ay ? ax : ay) * stroke;
        if (cut_short)
            ticks = ticks > 0 ? $urandom_range(ticks - 1) : 0;
        else
            ticks += $urandom_range(2);
        send_start(x1, y1, x2, y2, stroke);
        send_ticks(ticks);
    endtask

    task automatic degenerate_line();
        int x1;
        int y1;
        x1 = pick_coord();
        y1 = pick_coord();
        if ($urandom_range(1))
            send_start(x1, y1, x1, y1, $urandom_range(31));
        else
            send_start(x1, y1, pick_coord(), pick_coord(), 0);
        send_ticks($urandom_range(2, 1));
    endtask

    initial
    begin
        int          r;
        int          target;
        int unsigned pitch;
        int unsigned color;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_ticks(1);
        send_start(100, 200, 100, 200, 5);
        send_ticks(2);
        send_start(10, 10, 300, 40, 0);
        send_ticks(2);
        send_start(0, 0, 2, 1, 3);
        send_ticks(7);
        send_start(COORD_MAX, COORD_MAX, COORD_MAX - 1, COORD_MAX - 3, 2);
        send_ticks(3);
        send_start(COORD_MAX, 0, 0, COORD_MAX, 31);
        send_ticks(4);
        send_start(0, COORD_MAX, COORD_MAX, 0, 1);
        send_ticks(2);
        drain_results();

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:
                begin
                    pitch = (1 << lrs_pkg::PITCH_W) - 1;
                    color = 0;
                end
                1:
                begin
                    pitch = 0;
                    color = (1 << lrs_pkg::COLOR_W) - 1;
                end
                2:
                begin
                    pitch = 1;
                    color = $urandom_range((1 << lrs_pkg::COLOR_W) - 1);
                end
                default:
                begin
                    pitch = $urandom_range(3) == 0 ? 3 * (COORD_MAX + 1)
                                                   : $urandom_range((1 << lrs_pkg::PITCH_W) - 1);
                    color = $urandom_range((1 << lrs_pkg::COLOR_W) - 1);
                end
            endcase
            write_config(pitch, color);
            case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 62;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 62;
                end
                default:
                begin
                    send_idle_pct  = 27;
                    recv_stall_pct = 27;
                end
            endcase
            target = tracker.items_taken + PHASE_ITEMS;
            while (tracker.items_taken < target)
            begin
                r = $urandom_range(99);
                if (r < 75)
                    random_line(1'b0);
                else if (r < 88)
                    random_line(1'b1);
                else if (r < 94)
                    degenerate_line();
                else
                    send_ticks($urandom_range(3, 1));
            end
            drain_results();
        end

        if (tracker.errors == 0 && tracker.pending_pixels.size() == 0)
            $display("tb_line_rasterizer_with_stroke_top OK");
        else
            $display("tb_line_rasterizer_with_stroke_top NOT OK");
        $finish;
    end

endmodule
